// ===== rtl/core/mug_pkg.sv =====
// ----------------------------------------------------------------------------
// mug_pkg
// Shared types and constants of the monotonic ULID generator: field widths,
// RC4 sequencer states, command and status words between core and RC4 unit.
// ----------------------------------------------------------------------------
package mug_pkg;

  // field widths
  localparam int unsigned STAMP_W      = 48;
  localparam int unsigned RANDOM_BYTES = 10;
  localparam int unsigned RAND_W       = 8 * RANDOM_BYTES;
  localparam int unsigned UPPER_W      = 16;
  localparam int unsigned LOWER_W      = RAND_W - UPPER_W;
  localparam int unsigned HIGH_W       = STAMP_W + UPPER_W;

  // permutation box
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELAXED  = 1'b0,
    REG_PARANOID = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_KEY = 1'b0,
    ACT_GEN = 1'b1
  } action_e;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_DRAW = 1'b1
  } rc4_op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_K_RD,
    ST_K_WA,
    ST_K_WB,
    ST_G_RJ,
    ST_G_WI,
    ST_G_WJ,
    ST_G_OUT
  } rc4_state_e;

  typedef struct packed {
    logic         start;
    rc4_op_e      op;
    logic [7:0]   key;
  } rc4_cmd_t;

  typedef struct packed {
    logic         idle;
    logic         byte_valid;
    logic         last;
    logic [7:0]   data;
  } rc4_sts_t;

endpackage

// ===== rtl/core/mug_in_if.sv =====
// ----------------------------------------------------------------------------
// mug_in_if
// Input channel: one word is a key byte to mix or a timestamp to stamp.
// ----------------------------------------------------------------------------
interface mug_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [7:0]                   key_byte;
  logic [mug_pkg::STAMP_W-1:0]  timestamp_ms;

  modport source (output valid, output action, output key_byte, output timestamp_ms,
                  input ready);
  modport sink (input valid, input action, input key_byte, input timestamp_ms,
                output ready);
endinterface

// ===== rtl/core/mug_out_if.sv =====
// ----------------------------------------------------------------------------
// mug_out_if
// Result channel: one word is one 128-bit identifier plus its increment flag.
// ----------------------------------------------------------------------------
interface mug_out_if;
  logic                          valid;
  logic                          ready;
  logic [mug_pkg::HIGH_W-1:0]    id_high;
  logic [mug_pkg::LOWER_W-1:0]   id_low;
  logic                          was_incremented;

  modport source (output valid, output id_high, output id_low, output was_incremented,
                  input ready);
  modport sink (input valid, input id_high, input id_low, input was_incremented,
                output ready);
endinterface

// ===== rtl/core/mug_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mug_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mug_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mug_pkg::CFG_IDX_W-1:0]   index;
  logic [mug_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mug_ram.sv =====
// ----------------------------------------------------------------------------
// mug_ram
// Generic single write port, single read port RAM with registered read data
// (read returns the contents before a same-cycle write).
// ----------------------------------------------------------------------------
module mug_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mug_rc4_unit.sv =====
// ----------------------------------------------------------------------------
// mug_rc4_unit
// RC4 sequencer around one permutation RAM: identity fill after reset, one
// key-schedule step per key command, a run of keystream bytes per draw.
// ----------------------------------------------------------------------------
module mug_rc4_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mug_pkg::rc4_cmd_t cmd_i,
  output mug_pkg::rc4_sts_t sts_o
);

  mug_pkg::rc4_state_e state_q, state_d;

  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic [7:0] mi_q, mi_d;
  logic [7:0] mj_q, mj_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] a_q, a_d;
  logic [7:0] b_q, b_d;
  logic [7:0] key_q, key_d;

  logic                        ram_we;
  logic [mug_pkg::SBOX_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [mug_pkg::SBOX_AW-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;

  logic [7:0] mj_sum;
  logic [7:0] j_sum;
  logic [7:0] ks_idx;
  logic [7:0] i_next;
  logic       last_byte;

  mug_ram #(
    .WIDTH (8),
    .DEPTH (mug_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // index arithmetic, all modulo 256
  assign mj_sum    = 8'(mj_q + ram_rdata + key_q);
  assign j_sum     = 8'(j_q + ram_rdata);
  assign ks_idx    = 8'(a_q + b_q);
  assign i_next    = 8'(i_q + 8'd1);
  assign last_byte = (cnt_q == 8'(mug_pkg::RANDOM_BYTES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mug_pkg::ST_INIT: begin
        if (cnt_q == 8'(mug_pkg::SBOX_DEPTH - 1)) state_d = mug_pkg::ST_IDLE;
      end
      mug_pkg::ST_IDLE: begin
        if (cmd_i.start) begin
          state_d = (cmd_i.op == mug_pkg::OP_KEY) ? mug_pkg::ST_K_RD : mug_pkg::ST_G_RJ;
        end
      end
      mug_pkg::ST_K_RD:  state_d = mug_pkg::ST_K_WA;
      mug_pkg::ST_K_WA:  state_d = mug_pkg::ST_K_WB;
      mug_pkg::ST_K_WB:  state_d = mug_pkg::ST_IDLE;
      mug_pkg::ST_G_RJ:  state_d = mug_pkg::ST_G_WI;
      mug_pkg::ST_G_WI:  state_d = mug_pkg::ST_G_WJ;
      mug_pkg::ST_G_WJ:  state_d = mug_pkg::ST_G_OUT;
      mug_pkg::ST_G_OUT: state_d = last_byte ? mug_pkg::ST_IDLE : mug_pkg::ST_G_RJ;
      default:           state_d = mug_pkg::ST_IDLE;
    endcase
  end

  // ram control, datapath updates and status
  always_comb begin
    i_d       = i_q;
    j_d       = j_q;
    mi_d      = mi_q;
    mj_d      = mj_q;
    cnt_d     = cnt_q;
    a_d       = a_q;
    b_d       = b_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    sts_o     = '0;
    case (state_q)
      mug_pkg::ST_INIT: begin
        // identity fill, entry k gets k
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = cnt_q;
        cnt_d     = 8'(cnt_q + 8'd1);
      end
      mug_pkg::ST_IDLE: begin
        sts_o.idle = 1'b1;
        if (cmd_i.start) begin
          key_d = cmd_i.key;
          cnt_d = '0;
          if (cmd_i.op == mug_pkg::OP_KEY) begin
            ram_raddr = mi_q;
          end else begin
            i_d       = i_next;
            ram_raddr = i_next;
          end
        end
      end
      mug_pkg::ST_K_RD: begin
        a_d       = ram_rdata;
        mj_d      = mj_sum;
        ram_raddr = mj_sum;
      end
      mug_pkg::ST_K_WA: begin
        ram_we    = 1'b1;
        ram_waddr = mi_q;
        ram_wdata = ram_rdata;
      end
      mug_pkg::ST_K_WB: begin
        ram_we    = 1'b1;
        ram_waddr = mj_q;
        ram_wdata = a_q;
        mi_d      = 8'(mi_q + 8'd1);
      end
      mug_pkg::ST_G_RJ: begin
        a_d       = ram_rdata;
        j_d       = j_sum;
        ram_raddr = j_sum;
      end
      mug_pkg::ST_G_WI: begin
        b_d       = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      mug_pkg::ST_G_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
        ram_raddr = ks_idx;
      end
      mug_pkg::ST_G_OUT: begin
        // forward the entry written in the same cycle as the output read
        sts_o.byte_valid = 1'b1;
        sts_o.last       = last_byte;
        sts_o.data       = (ks_idx == j_q) ? a_q : ram_rdata;
        if (!last_byte) begin
          cnt_d     = 8'(cnt_q + 8'd1);
          i_d       = i_next;
          ram_raddr = i_next;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mug_pkg::ST_INIT;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      mi_q    <= '0;
      mj_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      mi_q    <= mi_d;
      mj_q    <= mj_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    key_q <= key_d;
  end

endmodule

// ===== rtl/core/monotonic_ulid_generator.sv =====
// ----------------------------------------------------------------------------
// monotonic_ulid_generator
// 128-bit ULID source: 48-bit timestamp plus 80-bit RC4-drawn random field,
// with monotonic increment on repeated timestamps.
// ----------------------------------------------------------------------------
// After reset the block fills its 256-entry RC4 permutation RAM with the
// identity; input ready stays low meanwhile, while configuration writes are
// taken at any time. All RC4 work runs through that one RAM (one write and one
// read port, registered read) under a small sequencer: a key word runs states
// K_RD, K_WA, K_WB; a fresh identifier draws ten keystream bytes, each through
// G_RJ, G_WI, G_WJ, G_OUT; a repeated timestamp in monotonic mode gets an 80-bit
// increment, registered in the cycle after it is taken. One word is worked on
// at a time; a finished identifier waits in an output register, and the next
// word is taken as soon as that register is free or being read.
module monotonic_ulid_generator (
  input  logic   clk_i,
  input  logic   rst_ni,
  mug_cfg_if.sink  cfg_i,
  mug_in_if.sink   in_i,
  mug_out_if.source out_o
);

  logic relaxed_q, relaxed_d;
  logic paranoid_q, paranoid_d;

  logic [mug_pkg::STAMP_W-1:0] last_stamp_q, last_stamp_d;
  logic [mug_pkg::RAND_W-1:0]  rand_q, rand_d;

  logic                         out_valid_q, out_valid_d;
  logic [mug_pkg::HIGH_W-1:0]   out_high_q, out_high_d;
  logic [mug_pkg::LOWER_W-1:0]  out_low_q, out_low_d;
  logic                         out_inc_q, out_inc_d;

  mug_pkg::rc4_cmd_t rc4_cmd;
  mug_pkg::rc4_sts_t rc4_sts;

  logic                        slot_free;
  logic                        in_acc;
  logic                        is_gen;
  logic                        bump;
  logic                        load;
  logic [mug_pkg::RAND_W-1:0]  rand_inc;
  logic [mug_pkg::RAND_W-1:0]  rand_shift;
  logic [mug_pkg::RAND_W-1:0]  rand_fresh;

  mug_rc4_unit u_rc4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rc4_cmd),
    .sts_o  (rc4_sts)
  );

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign in_i.ready  = rc4_sts.idle && slot_free;
  assign in_acc      = in_i.valid && in_i.ready;

  // monotonic decision
  assign is_gen = (in_i.action == mug_pkg::ACT_GEN);
  assign bump   = is_gen && !relaxed_q && (in_i.timestamp_ms == last_stamp_q);

  assign rc4_cmd.start = in_acc && !bump;
  assign rc4_cmd.op    = is_gen ? mug_pkg::OP_DRAW : mug_pkg::OP_KEY;
  assign rc4_cmd.key   = in_i.key_byte;

  // random field candidates
  assign rand_inc   = mug_pkg::RAND_W'(rand_q + 1'b1);
  assign rand_shift = {rand_q[mug_pkg::RAND_W-9:0], rc4_sts.data};
  assign rand_fresh = paranoid_q ? {1'b0, rand_shift[mug_pkg::RAND_W-2:0]} : rand_shift;

  // configuration writes
  always_comb begin
    relaxed_d  = relaxed_q;
    paranoid_d = paranoid_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (mug_pkg::cfg_reg_e'(cfg_i.index))
        mug_pkg::REG_RELAXED:  relaxed_d  = cfg_i.data[0];
        mug_pkg::REG_PARANOID: paranoid_d = cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // stamp, random field and result word
  always_comb begin
    last_stamp_d = last_stamp_q;
    rand_d       = rand_q;
    load         = 1'b0;
    out_inc_d    = out_inc_q;
    if (in_acc && bump) begin
      rand_d    = rand_inc;
      load      = 1'b1;
      out_inc_d = 1'b1;
    end else if (in_acc && is_gen) begin
      last_stamp_d = in_i.timestamp_ms;
    end
    if (rc4_sts.byte_valid) begin
      rand_d = rc4_sts.last ? rand_fresh : rand_shift;
      if (rc4_sts.last) begin
        load      = 1'b1;
        out_inc_d = 1'b0;
      end
    end
    out_high_d  = load ? {last_stamp_q, rand_d[mug_pkg::RAND_W-1:mug_pkg::LOWER_W]}
                       : out_high_q;
    out_low_d   = load ? rand_d[mug_pkg::LOWER_W-1:0] : out_low_q;
    out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relaxed_q    <= 1'b0;
      paranoid_q   <= 1'b1;
      last_stamp_q <= '0;
      rand_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      relaxed_q    <= relaxed_d;
      paranoid_q   <= paranoid_d;
      last_stamp_q <= last_stamp_d;
      rand_q       <= rand_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_high_q <= out_high_d;
    out_low_q  <= out_low_d;
    out_inc_q  <= out_inc_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.id_high         = out_high_q;
  assign out_o.id_low          = out_low_q;
  assign out_o.was_incremented = out_inc_q;

`ifndef ASSERT_OFF
  // a finished draw never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc4_sts.last |-> !out_valid_q)
    else $error("draw finished while result register occupied");

  // a repeated timestamp in monotonic mode answers with an increment next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && bump) |=> (out_valid_q && out_inc_q))
    else $error("monotonic increment not delivered");

  // paranoid fresh draws have the top random bit clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc4_sts.last && paranoid_q) |=> !out_high_q[mug_pkg::UPPER_W-1])
    else $error("paranoid draw with top random bit set");
`endif

endmodule
